>>> rtl/core/bss_pkg.sv
// Shared types and constants for the byte shuffle engine.
package bss_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int STRIDE_W         = 7;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd4;
    localparam int PASS_FACTOR      = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overflow;
    } out_beat_t;

endpackage

>>> rtl/core/bss_fifo.sv
// Two-entry queue carrying run descriptors from the load side to the drain side.
module bss_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    import bss_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/bss_front.sv
// Load side: stores bytes, tracks count and overflow, emits one descriptor per run.
module bss_front #(
    parameter int BUFFER_BYTES = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bss_pkg::in_beat_t               in_data,
    input  logic                            cfg_valid,
    input  logic [bss_pkg::STRIDE_W-1:0]    cfg_data,
    input  logic                            hold,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output logic [7:0]                      wr_data,
    output logic                            desc_push,
    output logic [CW+bss_pkg::STRIDE_W:0]   desc_data
);
    import bss_pkg::*;

    localparam int CMPW = (CW > STRIDE_W + 1) ? CW : STRIDE_W + 1;

    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                accept, full, pass;
    logic [CW-1:0]       n_fin;
    logic [STRIDE_W-1:0] s_raw, s_eff;

    assign in_ready = !hold;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(BUFFER_BYTES));

    assign wr_en    = accept && !full;
    assign wr_addr  = count_reg[AW-1:0];
    assign wr_data  = in_data.data_byte;

    always_comb
    begin
        n_fin = full ? count_reg : count_reg + CW'(1);
        // zero stride behaves as one
        s_raw = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
        pass  = CMPW'(n_fin) < CMPW'(PASS_FACTOR) * CMPW'(s_raw);
        s_eff = pass ? STRIDE_W'(1) : s_raw;

        desc_push = accept && in_data.is_last;
        desc_data = {n_fin, s_eff, ovf_reg || full};

        stride_next = cfg_valid ? cfg_data : stride_reg;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (desc_push)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            stride_reg <= stride_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

>>> rtl/core/bss_back.sv
// Drain side: byte store and column-major read sequencer with registered output.
module bss_back #(
    parameter int BUFFER_BYTES = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            desc_valid,
    input  logic [CW+bss_pkg::STRIDE_W:0]   desc_data,
    output logic                            desc_pop,
    output logic                            busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bss_pkg::out_beat_t              out_data
);
    import bss_pkg::*;

    localparam int SW = ((CW > STRIDE_W) ? CW : STRIDE_W) + 1;

    logic [7:0]          mem [BUFFER_BYTES];

    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [STRIDE_W-1:0] s_reg, s_next;
    logic                ovf_reg, ovf_next;
    logic [AW-1:0]       src_reg, src_next;
    logic [STRIDE_W-1:0] col_reg, col_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [7:0]          rd_byte_reg;
    logic                last_reg, ovf_out_reg;

    logic                issue, k_last, wrap;
    logic [SW-1:0]       src_sum;
    logic [STRIDE_W-1:0] col_inc;

    assign desc_pop  = desc_valid && !active_reg;
    assign issue     = active_reg && (!out_valid_reg || out_ready);
    assign busy      = active_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = '{out_byte: rd_byte_reg, out_last: last_reg, overflow: ovf_out_reg};

    always_comb
    begin
        k_last  = ((CW+1)'(k_reg) + (CW+1)'(1)) == (CW+1)'(n_reg);
        src_sum = SW'(src_reg) + SW'(s_reg);
        wrap    = src_sum >= SW'(n_reg);
        col_inc = col_reg + STRIDE_W'(1);

        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        ovf_next       = ovf_reg;
        src_next       = src_reg;
        col_next       = col_reg;
        k_next         = k_reg;

        if (desc_pop)
        begin
            // load a new run and start at column zero
            active_next = 1'b1;
            n_next      = desc_data[CW+STRIDE_W:STRIDE_W+1];
            s_next      = desc_data[STRIDE_W:1];
            ovf_next    = desc_data[0];
            src_next    = '0;
            col_next    = '0;
            k_next      = '0;
        end
        else if (issue)
        begin
            k_next = k_reg + CW'(1);
            if (k_last)
            begin
                active_next = 1'b0;
            end
            if (wrap)
            begin
                col_next = col_inc;
                src_next = AW'(col_inc);
            end
            else
            begin
                src_next = src_sum[AW-1:0];
            end
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        s_reg   <= s_next;
        ovf_reg <= ovf_next;
        src_reg <= src_next;
        col_reg <= col_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_byte_reg <= mem[src_reg];
            last_reg    <= k_last;
            ovf_out_reg <= ovf_reg;
        end
    end

endmodule

>>> rtl/core/byte_shuffle_stride.sv
// Top level of the byte shuffle engine: load side, descriptor queue, drain side.
//
// Input beats carry one byte and an is_last mark. Bytes are written into a
// store of BUFFER_BYTES entries; loads that find the store full are dropped
// and flag the run as overflowed. The beat with is_last closes the buffer and
// queues a run of n bytes for the drain side.
// The drain side reads the store in column-major order: every stride-th byte
// from offset 0, then from offset 1, up to offset stride-1. Runs shorter than
// twice the stride (or stride zero) come out in load order.
// Once the is_last beat is accepted, its descriptor passes through the queue,
// the drain side loads it and reads the first byte into the output register;
// then one beat per cycle while out_ready is high. in_ready drops from the
// cycle after is_last until the drain has read its last byte, so loading and
// draining never overlap; the single shared store sets that.
// The output register lets the next buffer load while the final byte waits.
// A stalled receiver holds the output register and pauses the read sequencer.
// The stride register is written on the cfg channel (always ready) and must
// only change while the block is idle. Reset clears the counts, the queue and
// the output valid, and sets stride to 4; the store needs no clearing.
module byte_shuffle_stride #(
    parameter int BUFFER_BYTES = bss_pkg::BUFFER_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bss_pkg::in_beat_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bss_pkg::out_beat_t           out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bss_pkg::STRIDE_W-1:0] cfg_data
);
    import bss_pkg::*;

    // store address and byte count widths
    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    // descriptor: {n, effective stride, overflow}
    localparam int DW = CW + STRIDE_W + 1;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          desc_push, desc_pop, desc_valid, desc_full;
    logic [DW-1:0] desc_in, desc_out;
    logic          back_busy;
    logic          hold;

    // the store is shared, so hold loads while any run is queued or draining
    assign hold      = desc_valid || back_busy;
    assign cfg_ready = 1'b1;

    bss_front #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW          (AW),
        .CW          (CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .hold     (hold),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .desc_push(desc_push),
        .desc_data(desc_in)
    );

    bss_fifo #(
        .WIDTH(DW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (desc_push),
        .push_data(desc_in),
        .full     (desc_full),
        .pop      (desc_pop),
        .pop_data (desc_out),
        .not_empty(desc_valid)
    );

    bss_back #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW          (AW),
        .CW          (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .desc_valid(desc_valid),
        .desc_data (desc_out),
        .desc_pop  (desc_pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a byte load never overlaps a queued or draining run
    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!back_busy && !desc_valid))
        else $error("byte loaded while a run is pending");

    // a descriptor is never pushed into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("descriptor pushed into full queue");

    // the overflow flag stays constant across the beats of one run
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.out_last) |=>
        (!out_valid || (out_data.overflow == $past(out_data.overflow))))
        else $error("overflow flag changed inside a run");

endmodule

>>> tb/tb_byte_shuffle_stride.sv
// Self-checking testbench for the byte shuffle engine with a built-in column-major predictor.
module tb_byte_shuffle_stride;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    // Store depth matches the default parameter of the instance below.
    localparam int          STORE_DEPTH  = BUFFER_BYTES_DEF;
    localparam int          RANDOM_BEATS = 70;
    // Cycles to let pass after the last result before touching the stride.
    localparam int          SETTLE_CYC   = 8;
    // Cycles to hold at the very end, after the last result has arrived.
    localparam int          TAIL_CYC     = 40;
    // Slowest correct run: ~350 beats, each a sender gap, the block's own delay and a
    // long receiver stall, plus the settle waits; taken many times over.
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One directed buffer: optional stride write, length and a byte pattern.
    // When typed is set, the first result of the run is checked against
    // typed_first instead of the predictor.
    typedef struct {
        int          new_stride;   // -1 keeps the current stride
        int          len;
        logic [7:0]  first;
        logic [7:0]  step;
        bit          typed;
        out_beat_t   typed_first;
    } buf_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_beat_t            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_beat_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [STRIDE_W-1:0] cfg_data  = '0;

    // Predictor state: its own copy of the store, the fill count, the drop
    // flag and the stride register.
    logic [7:0]          byte_mem [STORE_DEPTH];
    int unsigned         fill_count   = 0;
    bit                  load_dropped = 1'b0;
    logic [STRIDE_W-1:0] col_stride   = STRIDE_RESET;

    // Shuffled bytes still owed by the block, oldest first.
    out_beat_t           shuffled_q [$];
    bit                  pin_first = 1'b0;
    out_beat_t           pinned_first;

    buf_row_t            plan [11];

    int                  send_idle_pct = 12;
    int                  recv_idle_pct = 67;
    int unsigned         cycle_count   = 0;
    int                  mismatches    = 0;
    int                  beats_sent    = 0;
    int                  buffers_sent  = 0;
    int                  overflow_runs = 0;
    int                  beats_checked = 0;
    int                  stride_writes = 0;

    byte_shuffle_stride u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Take one accepted byte into the predictor. On the marked last byte,
    // queue the whole run in column-major order (or load order when the run
    // is shorter than two rows), then clear the count and the drop flag.
    function automatic void take_byte(in_beat_t beat);
        int unsigned n;
        int unsigned s;
        int unsigned col;
        int unsigned src;
        int unsigned order [$];
        out_beat_t   res;

        if (fill_count < STORE_DEPTH)
        begin
            byte_mem[fill_count] = beat.data_byte;
            fill_count++;
        end
        else
        begin
            load_dropped = 1'b1;
        end

        if (!beat.is_last)
            return;

        n = fill_count;
        // A zero stride behaves like one: plain pass-through.
        s = (col_stride == 0) ? 1 : col_stride;
        if (n < PASS_FACTOR * s)
        begin
            for (src = 0; src < n; src++)
                order.push_back(src);
        end
        else
        begin
            for (col = 0; col < s; col++)
                for (src = col; src < n; src += s)
                    order.push_back(src);
        end

        foreach (order[k])
        begin
            res.out_byte = byte_mem[order[k]];
            res.out_last = (k + 1 == n);
            res.overflow = load_dropped;
            if (k == 0 && pin_first)
                res = pinned_first;
            shuffled_q.push_back(res);
        end

        if (load_dropped)
            overflow_runs++;
        pin_first    = 1'b0;
        fill_count   = 0;
        load_dropped = 1'b0;
    endfunction

    // Present one beat, holding valid and payload until it is accepted. Entered
    // and left just after a falling edge.
    task automatic send_beat(in_beat_t beat);
        // Idle the sender with valid low for a random number of cycles.
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Accepted at this edge: update the predictor before the run drains.
        take_byte(beat);
        beats_sent++;
        @(negedge clk);
    endtask

    // Send one buffer: either a fixed pattern first + i*step or random bytes;
    // the final beat carries is_last.
    task automatic send_buffer(int len, bit rand_bytes, logic [7:0] first, logic [7:0] step);
        in_beat_t beat;

        for (int i = 0; i < len; i++)
        begin
            beat.data_byte = rand_bytes ? 8'($urandom) : 8'(first + step * 8'(i));
            beat.is_last   = (i == len - 1);
            send_beat(beat);
        end
        buffers_sent++;
    endtask

    // Hold the sender until every owed beat has come out, then let the block
    // settle. Entered and left just after a falling edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (shuffled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    // Write the stride register over the cfg channel; only called when idle.
    task automatic write_stride(logic [STRIDE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        col_stride = value;
        stride_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: drop ready at random, driven on the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check every accepted output beat against the oldest owed beat.
    always @(posedge clk)
    begin : check_out
        out_beat_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (shuffled_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output beat: byte %h last %b overflow %b",
                         $time, out_data.out_byte, out_data.out_last, out_data.overflow);
            end
            else
            begin
                want = shuffled_q.pop_front();
                if (out_data.out_byte !== want.out_byte
                    || out_data.out_last !== want.out_last
                    || out_data.overflow !== want.overflow)
                begin
                    mismatches++;
                    $display("%0t: beat %0d: expected %h/%b/%b, got %h/%b/%b",
                             $time, beats_checked,
                             want.out_byte, want.out_last, want.overflow,
                             out_data.out_byte, out_data.out_last, out_data.overflow);
                end
                beats_checked++;
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d beats still owed",
                     $time, cycle_count, shuffled_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int          idle_phase;
        int          len;
        int          pick;
        int          random_beats;
        logic [STRIDE_W-1:0] next_stride;

        // Directed buffers. The reset stride of 4 is used first, then the
        // stride walks through one, zero, the store size, sixteen, the register
        // maximum and two with a store overflow.
        plan = '{
            // lone bytes right after reset: both byte extremes pass straight out
            '{-1,  1, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0}},
            '{-1,  1, 8'hFF, 8'h00, 1'b1, {8'hFF, 1'b1, 1'b0}},
            // one byte short of two rows: load order
            '{-1,  7, 8'h10, 8'h01, 1'b0, '0},
            // exactly two rows: first shuffled length
            '{-1,  8, 8'h20, 8'h01, 1'b0, '0},
            // ragged columns: length not a multiple of the stride
            '{-1, 10, 8'h30, 8'h11, 1'b0, '0},
            '{ 1,  5, 8'hA0, 8'h01, 1'b0, '0},
            // zero stride acts as one: first byte leads
            '{ 0,  6, 8'hC3, 8'h01, 1'b1, {8'hC3, 1'b0, 1'b0}},
            // full store with stride 64: below two rows, so unchanged
            '{64, 64, 8'h00, 8'h04, 1'b0, '0},
            '{16, 40, 8'h55, 8'h03, 1'b0, '0},
            // stride beyond the store
            '{127, 3, 8'hF0, 8'h01, 1'b1, {8'hF0, 1'b0, 1'b0}},
            // two loads past a full store, is_last on a dropped beat
            '{ 2, 66, 8'h80, 8'h01, 1'b1, {8'h80, 1'b0, 1'b1}}
        };

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < $size(plan); r++)
        begin
            if (plan[r].new_stride >= 0)
            begin
                wait_drained();
                write_stride(STRIDE_W'(plan[r].new_stride));
            end
            pin_first    = plan[r].typed;
            pinned_first = plan[r].typed_first;
            send_buffer(plan[r].len, 1'b0, plan[r].first, plan[r].step);
        end

        // Random buffers in three idle phases: sender light and receiver
        // heavy, then swapped, then no idling at all.
        random_beats = 0;
        idle_phase   = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            if (random_beats * 3 / RANDOM_BEATS != idle_phase)
            begin
                // Phase change: hold the sender until everything has drained.
                wait_drained();
                idle_phase = random_beats * 3 / RANDOM_BEATS;
                send_idle_pct = (idle_phase == 1) ? 67 : 0;
                recv_idle_pct = (idle_phase == 1) ? 12 : 0;
            end

            if ($urandom_range(99) < 20)
            begin
                wait_drained();
                pick = $urandom_range(99);
                if (pick < 60)
                    next_stride = STRIDE_W'($urandom_range(8, 1));
                else if (pick < 70)
                    next_stride = '0;
                else if (pick < 80)
                    next_stride = STRIDE_W'(STORE_DEPTH);
                else if (pick < 85)
                    next_stride = '1;
                else
                    next_stride = STRIDE_W'($urandom);
                write_stride(next_stride);
            end

            // Mostly short buffers, some mid-size, a few around the store size that may overflow.
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(16, 1);
            else if (pick < 90)
                len = $urandom_range(STORE_DEPTH - 1, 17);
            else
                len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 4);
            send_buffer(len, 1'b1, 8'h00, 8'h00);
            random_beats += (len > STORE_DEPTH) ? STORE_DEPTH : len;
        end

        // Drain everything, then give the block time to show stray beats.
        in_valid <= 1'b0;
        while (shuffled_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        $display("Run covered %0d input beats in %0d buffers, %0d of them overflowed.",
                 beats_sent, buffers_sent, overflow_runs);
        $display("Checked %0d output beats across %0d stride writes, %0d mismatches.",
                 beats_checked, stride_writes, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
